// ===== sv/doac_pkg.sv =====
`default_nettype none
package doac_pkg;

  // Counter widths of the encoder positions and of the stage timer
  localparam int COUNT_WIDTH = 16;
  localparam int TIMER_WIDTH = 16;

  // Field and register widths
  localparam int REQ_W    = 2;
  localparam int CODE_W   = 8;
  localparam int ECHO_W   = 16;
  localparam int THR_W    = 10;
  localparam int TIME_W   = 16;
  localparam int PWM_W    = 8;
  localparam int LIMIT_W  = 15;
  localparam int POS_W    = 16;
  localparam int STAGE_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Compare widths wide enough for both operands
  localparam int CMP_W  = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
  localparam int TCMP_W = (TIMER_WIDTH > TIME_W) ? TIMER_WIDTH : TIME_W;

  // echo_us*17 and threshold*1000 both fit in 21 bits
  localparam int PROD_W      = 21;
  localparam int ECHO_SCALE  = 17;
  localparam int THR_SCALE   = 1000;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_FWD   = 3'd1,
    MODE_BACK  = 3'd2,
    MODE_LEFT  = 3'd3,
    MODE_RIGHT = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    STG_NONE    = 4'b0001,
    STG_REVERSE = 4'b0010,
    STG_TURN    = 4'b0100,
    STG_DONE    = 4'b1000
  } stage_t;

  localparam logic [STAGE_W-1:0] AVOID_NONE    = 2'd0;
  localparam logic [STAGE_W-1:0] AVOID_REVERSE = 2'd1;
  localparam logic [STAGE_W-1:0] AVOID_TURN    = 2'd2;
  localparam logic [STAGE_W-1:0] AVOID_DONE    = 2'd3;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK = 2'd0,
    REQ_CMD  = 2'd1,
    REQ_ECHO = 2'd2,
    REQ_ENC  = 2'd3
  } req_t;

  localparam logic [CODE_W-1:0] CMD_FWD   = 8'h46;  // 'F'
  localparam logic [CODE_W-1:0] CMD_BACK  = 8'h42;  // 'B'
  localparam logic [CODE_W-1:0] CMD_LEFT  = 8'h4C;  // 'L'
  localparam logic [CODE_W-1:0] CMD_RIGHT = 8'h52;  // 'R'
  localparam logic [CODE_W-1:0] CMD_STOP  = 8'h53;  // 'S'

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD   = 3'd0,
    CFG_REVERSE_MS  = 3'd1,
    CFG_TURN_MS     = 3'd2,
    CFG_DRIVE_PWM   = 3'd3,
    CFG_RESUME_PWM1 = 3'd4,
    CFG_TURN_PWM0   = 3'd5,
    CFG_TURN_PWM1   = 3'd6,
    CFG_TRAVEL_LIM  = 3'd7
  } cfg_idx_t;

  function automatic logic [STAGE_W-1:0] stage_code(input stage_t s);
    logic [STAGE_W-1:0] c;
    unique case (s)
      STG_NONE:    c = AVOID_NONE;
      STG_REVERSE: c = AVOID_REVERSE;
      STG_TURN:    c = AVOID_TURN;
      STG_DONE:    c = AVOID_DONE;
      default:     c = AVOID_NONE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/doac_ifs.sv =====
`default_nettype none
interface doac_in_if;
  logic                          valid;
  logic                          ready;
  logic [doac_pkg::REQ_W-1:0]    req_type;
  logic [doac_pkg::CODE_W-1:0]   command_code;
  logic [doac_pkg::ECHO_W-1:0]   echo_us;
  logic                          encoder_motor;
  logic                          encoder_b_level;
  logic                          turn_choice;

  modport source (
    output valid, req_type, command_code, echo_us, encoder_motor,
           encoder_b_level, turn_choice,
    input  ready
  );
  modport sink (
    input  valid, req_type, command_code, echo_us, encoder_motor,
           encoder_b_level, turn_choice,
    output ready
  );
endinterface

interface doac_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         motor0_dir;
  logic [doac_pkg::PWM_W-1:0]         motor0_duty;
  logic [1:0]                         motor1_dir;
  logic [doac_pkg::PWM_W-1:0]         motor1_duty;
  logic [doac_pkg::STAGE_W-1:0]       avoid_stage;
  logic                               obstacle_flag;
  logic signed [doac_pkg::POS_W-1:0]  position0;
  logic signed [doac_pkg::POS_W-1:0]  position1;
  logic                               invalid_command;

  modport source (
    output valid, motor0_dir, motor0_duty, motor1_dir, motor1_duty,
           avoid_stage, obstacle_flag, position0, position1, invalid_command,
    input  ready
  );
  modport sink (
    input  valid, motor0_dir, motor0_duty, motor1_dir, motor1_duty,
           avoid_stage, obstacle_flag, position0, position1, invalid_command,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/drive_obstacle_avoid_controller_core.sv =====
`default_nettype none
// Channel   Direction  Beat contents
// in_chan   sink       req_type, command_code, echo_us, encoder_motor,
//                      encoder_b_level, turn_choice
// out_chan  source     motor0/1 dir and duty, avoid_stage, obstacle_flag,
//                      position0/1, invalid_command
// cfg_*     write      cfg_we, cfg_index, cfg_data (no read-back)
//
// One beat in, one beat out. A beat is taken in any cycle where the result
// register is empty or is being drained, so the block runs at one beat per
// cycle; the result is registered on acceptance and appears in the next cycle.
// All state updates happen in one combinational pass on acceptance.
// rst_n is synchronous active low: it restores the register defaults, stops
// both motors, clears positions and marks and empties the result register.
// A stall on out_chan holds the result and back-pressures in_chan.
module drive_obstacle_avoid_controller_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  doac_in_if.sink                                in_chan,
  doac_out_if.source                             out_chan,
  input  wire logic                              cfg_we,
  input  wire logic [doac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [doac_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = doac_pkg::COUNT_WIDTH;
  localparam int TW = doac_pkg::TIMER_WIDTH;

  // Configuration registers
  logic [doac_pkg::THR_W-1:0]   thr_r;
  logic [doac_pkg::TIME_W-1:0]  reverse_ms_r;
  logic [doac_pkg::TIME_W-1:0]  turn_ms_r;
  logic [doac_pkg::PWM_W-1:0]   drive_pwm_r;
  logic [doac_pkg::PWM_W-1:0]   resume_pwm1_r;
  logic [doac_pkg::PWM_W-1:0]   turn_pwm0_r;
  logic [doac_pkg::PWM_W-1:0]   turn_pwm1_r;
  logic [doac_pkg::LIMIT_W-1:0] travel_lim_r;

  // Controller state
  doac_pkg::stage_t             stage_r,   stage_nxt;
  doac_pkg::mode_t              mode_r,    mode_nxt;
  logic                         moving_r,  moving_nxt;
  logic                         obst_r,    obst_nxt;
  logic                         sense_r,   sense_nxt;
  logic [TW-1:0]                elapsed_r, elapsed_nxt;
  logic [CW-1:0]                pos_r  [2];
  logic [CW-1:0]                pos_nxt[2];
  logic [CW-1:0]                mark_r [2];
  logic [CW-1:0]                mark_nxt[2];
  doac_pkg::dir_t               dir_r  [2];
  doac_pkg::dir_t               dir_nxt[2];
  logic [doac_pkg::PWM_W-1:0]   duty_r [2];
  logic [doac_pkg::PWM_W-1:0]   duty_nxt[2];
  logic                         invalid_nxt;

  // Result register
  logic                         out_valid_r;
  logic [1:0]                   o_dir0_r, o_dir1_r;
  logic [doac_pkg::PWM_W-1:0]   o_duty0_r, o_duty1_r;
  logic [doac_pkg::STAGE_W-1:0] o_stage_r;
  logic                         o_obst_r;
  logic signed [doac_pkg::POS_W-1:0] o_pos0_r, o_pos1_r;
  logic                         o_invalid_r;

  // Datapath helpers
  logic                         in_acc;
  doac_pkg::req_t               req;
  logic [CW-1:0]                diff   [2];
  logic [TW-1:0]                elapsed_inc;
  logic [doac_pkg::PROD_W-1:0]  echo_prod;
  logic [doac_pkg::PROD_W-1:0]  thr_prod;
  logic                         near;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign req           = doac_pkg::req_t'(in_chan.req_type);

  // Saturating increment of the stage timer
  assign elapsed_inc = (elapsed_r == {TW{1'b1}}) ? elapsed_r : elapsed_r + 1'b1;

  // Obstacle test: echo_us*17 < threshold_cm*1000 (exact form of the
  // 0.034/2 cm-per-us conversion followed by a floor)
  assign echo_prod = doac_pkg::PROD_W'(in_chan.echo_us)
                   * doac_pkg::PROD_W'(doac_pkg::ECHO_SCALE);
  assign thr_prod  = doac_pkg::PROD_W'(thr_r)
                   * doac_pkg::PROD_W'(doac_pkg::THR_SCALE);
  assign near      = echo_prod < thr_prod;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      diff[k] = pos_r[k] - mark_r[k];
    end
  end

  always_comb begin
    stage_nxt   = stage_r;
    mode_nxt    = mode_r;
    moving_nxt  = moving_r;
    obst_nxt    = obst_r;
    sense_nxt   = sense_r;
    elapsed_nxt = elapsed_r;
    invalid_nxt = 1'b0;
    for (int k = 0; k < 2; k++) begin
      pos_nxt[k]  = pos_r[k];
      mark_nxt[k] = mark_r[k];
      dir_nxt[k]  = dir_r[k];
      duty_nxt[k] = duty_r[k];
    end

    unique case (req)
      doac_pkg::REQ_TICK: begin
        // Travel limit first: stop a motor whose forward travel since its
        // mark reached the limit, and move the mark up to the count
        for (int k = 0; k < 2; k++) begin
          if (!diff[k][CW-1] &&
              doac_pkg::CMP_W'(diff[k]) >= doac_pkg::CMP_W'(travel_lim_r)) begin
            dir_nxt[k]  = doac_pkg::DIR_STOP;
            duty_nxt[k] = '0;
            mark_nxt[k] = pos_r[k];
          end
        end
        // Then advance the avoidance sequence
        if (moving_r) begin
          unique case (stage_r)
            doac_pkg::STG_NONE: begin
              if (obst_r) begin
                stage_nxt   = doac_pkg::STG_REVERSE;
                elapsed_nxt = '0;
                sense_nxt   = 1'b0;
                dir_nxt[0]  = doac_pkg::DIR_REV;
                duty_nxt[0] = drive_pwm_r;
                dir_nxt[1]  = doac_pkg::DIR_REV;
                duty_nxt[1] = drive_pwm_r;
              end
            end
            doac_pkg::STG_REVERSE: begin
              elapsed_nxt = elapsed_inc;
              if (doac_pkg::TCMP_W'(elapsed_inc) >= doac_pkg::TCMP_W'(reverse_ms_r)) begin
                stage_nxt   = doac_pkg::STG_TURN;
                elapsed_nxt = '0;
                dir_nxt[0]  = in_chan.turn_choice ? doac_pkg::DIR_FWD : doac_pkg::DIR_REV;
                duty_nxt[0] = turn_pwm0_r;
                dir_nxt[1]  = in_chan.turn_choice ? doac_pkg::DIR_REV : doac_pkg::DIR_FWD;
                duty_nxt[1] = turn_pwm1_r;
              end
            end
            doac_pkg::STG_TURN: begin
              elapsed_nxt = elapsed_inc;
              if (doac_pkg::TCMP_W'(elapsed_inc) >= doac_pkg::TCMP_W'(turn_ms_r)) begin
                stage_nxt   = doac_pkg::STG_DONE;
                dir_nxt[0]  = doac_pkg::DIR_STOP;
                duty_nxt[0] = '0;
                dir_nxt[1]  = doac_pkg::DIR_STOP;
                duty_nxt[1] = '0;
              end
            end
            doac_pkg::STG_DONE: begin
              // Resume the commanded drive; idle resumes nothing
              case (mode_r)
                doac_pkg::MODE_FWD: begin
                  dir_nxt[0]  = doac_pkg::DIR_FWD;
                  duty_nxt[0] = drive_pwm_r;
                  dir_nxt[1]  = doac_pkg::DIR_FWD;
                  duty_nxt[1] = resume_pwm1_r;
                end
                doac_pkg::MODE_BACK: begin
                  dir_nxt[0]  = doac_pkg::DIR_REV;
                  duty_nxt[0] = drive_pwm_r;
                  dir_nxt[1]  = doac_pkg::DIR_REV;
                  duty_nxt[1] = resume_pwm1_r;
                end
                doac_pkg::MODE_LEFT: begin
                  dir_nxt[0]  = doac_pkg::DIR_REV;
                  duty_nxt[0] = turn_pwm0_r;
                  dir_nxt[1]  = doac_pkg::DIR_FWD;
                  duty_nxt[1] = turn_pwm1_r;
                end
                doac_pkg::MODE_RIGHT: begin
                  dir_nxt[0]  = doac_pkg::DIR_FWD;
                  duty_nxt[0] = turn_pwm0_r;
                  dir_nxt[1]  = doac_pkg::DIR_REV;
                  duty_nxt[1] = turn_pwm1_r;
                end
                default: begin
                end
              endcase
              stage_nxt = doac_pkg::STG_NONE;
              obst_nxt  = 1'b0;
              sense_nxt = 1'b1;
            end
            default: begin
              stage_nxt = doac_pkg::STG_NONE;
            end
          endcase
        end
      end

      doac_pkg::REQ_CMD: begin
        // Any command byte, even an unknown one, drops the avoidance stage
        stage_nxt = doac_pkg::STG_NONE;
        case (in_chan.command_code)
          doac_pkg::CMD_FWD: begin
            moving_nxt  = 1'b1;
            mode_nxt    = doac_pkg::MODE_FWD;
            sense_nxt   = 1'b1;
            dir_nxt[0]  = doac_pkg::DIR_FWD;
            duty_nxt[0] = drive_pwm_r;
            dir_nxt[1]  = doac_pkg::DIR_FWD;
            duty_nxt[1] = drive_pwm_r;
          end
          doac_pkg::CMD_BACK: begin
            moving_nxt  = 1'b1;
            mode_nxt    = doac_pkg::MODE_BACK;
            sense_nxt   = 1'b0;
            dir_nxt[0]  = doac_pkg::DIR_REV;
            duty_nxt[0] = drive_pwm_r;
            dir_nxt[1]  = doac_pkg::DIR_REV;
            duty_nxt[1] = drive_pwm_r;
          end
          doac_pkg::CMD_LEFT: begin
            moving_nxt  = 1'b1;
            mode_nxt    = doac_pkg::MODE_LEFT;
            sense_nxt   = 1'b1;
            dir_nxt[0]  = doac_pkg::DIR_REV;
            duty_nxt[0] = turn_pwm0_r;
            dir_nxt[1]  = doac_pkg::DIR_FWD;
            duty_nxt[1] = turn_pwm1_r;
          end
          doac_pkg::CMD_RIGHT: begin
            moving_nxt  = 1'b1;
            mode_nxt    = doac_pkg::MODE_RIGHT;
            sense_nxt   = 1'b1;
            dir_nxt[0]  = doac_pkg::DIR_FWD;
            duty_nxt[0] = turn_pwm0_r;
            dir_nxt[1]  = doac_pkg::DIR_REV;
            duty_nxt[1] = turn_pwm1_r;
          end
          doac_pkg::CMD_STOP: begin
            moving_nxt  = 1'b0;
            mode_nxt    = doac_pkg::MODE_IDLE;
            sense_nxt   = 1'b0;
            obst_nxt    = 1'b0;
            dir_nxt[0]  = doac_pkg::DIR_STOP;
            duty_nxt[0] = '0;
            dir_nxt[1]  = doac_pkg::DIR_STOP;
            duty_nxt[1] = '0;
          end
          default: begin
            invalid_nxt = 1'b1;
          end
        endcase
      end

      doac_pkg::REQ_ECHO: begin
        // Sample only while sensing and outside the avoidance sequence
        if (sense_r && stage_r == doac_pkg::STG_NONE) begin
          obst_nxt = near;
          if (near) begin
            dir_nxt[0]  = doac_pkg::DIR_STOP;
            duty_nxt[0] = '0;
            dir_nxt[1]  = doac_pkg::DIR_STOP;
            duty_nxt[1] = '0;
          end
        end
      end

      doac_pkg::REQ_ENC: begin
        for (int k = 0; k < 2; k++) begin
          if (in_chan.encoder_motor == 1'(k)) begin
            pos_nxt[k] = in_chan.encoder_b_level ? pos_r[k] + 1'b1 : pos_r[k] - 1'b1;
          end
        end
      end

      default: begin
      end
    endcase
  end

  // Control, state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r         <= doac_pkg::THR_W'(50);
      reverse_ms_r  <= doac_pkg::TIME_W'(1500);
      turn_ms_r     <= doac_pkg::TIME_W'(1000);
      drive_pwm_r   <= doac_pkg::PWM_W'(65);
      resume_pwm1_r <= doac_pkg::PWM_W'(64);
      turn_pwm0_r   <= doac_pkg::PWM_W'(45);
      turn_pwm1_r   <= doac_pkg::PWM_W'(50);
      travel_lim_r  <= doac_pkg::LIMIT_W'(5000);
      stage_r       <= doac_pkg::STG_NONE;
      mode_r        <= doac_pkg::MODE_IDLE;
      moving_r      <= 1'b0;
      obst_r        <= 1'b0;
      sense_r       <= 1'b0;
      elapsed_r     <= '0;
      for (int k = 0; k < 2; k++) begin
        pos_r[k]  <= '0;
        mark_r[k] <= '0;
        dir_r[k]  <= doac_pkg::DIR_STOP;
        duty_r[k] <= '0;
      end
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (doac_pkg::cfg_idx_t'(cfg_index))
          doac_pkg::CFG_THRESHOLD:   thr_r         <= cfg_data[doac_pkg::THR_W-1:0];
          doac_pkg::CFG_REVERSE_MS:  reverse_ms_r  <= cfg_data[doac_pkg::TIME_W-1:0];
          doac_pkg::CFG_TURN_MS:     turn_ms_r     <= cfg_data[doac_pkg::TIME_W-1:0];
          doac_pkg::CFG_DRIVE_PWM:   drive_pwm_r   <= cfg_data[doac_pkg::PWM_W-1:0];
          doac_pkg::CFG_RESUME_PWM1: resume_pwm1_r <= cfg_data[doac_pkg::PWM_W-1:0];
          doac_pkg::CFG_TURN_PWM0:   turn_pwm0_r   <= cfg_data[doac_pkg::PWM_W-1:0];
          doac_pkg::CFG_TURN_PWM1:   turn_pwm1_r   <= cfg_data[doac_pkg::PWM_W-1:0];
          doac_pkg::CFG_TRAVEL_LIM:  travel_lim_r  <= cfg_data[doac_pkg::LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        stage_r   <= stage_nxt;
        mode_r    <= mode_nxt;
        moving_r  <= moving_nxt;
        obst_r    <= obst_nxt;
        sense_r   <= sense_nxt;
        elapsed_r <= elapsed_nxt;
        for (int k = 0; k < 2; k++) begin
          pos_r[k]  <= pos_nxt[k];
          mark_r[k] <= mark_nxt[k];
          dir_r[k]  <= dir_nxt[k];
          duty_r[k] <= duty_nxt[k];
        end
      end
      // Hold the result until drained; refill on the same edge it drains
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: capture the post-update view on acceptance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      o_dir0_r    <= dir_nxt[0];
      o_duty0_r   <= duty_nxt[0];
      o_dir1_r    <= dir_nxt[1];
      o_duty1_r   <= duty_nxt[1];
      o_stage_r   <= doac_pkg::stage_code(stage_nxt);
      o_obst_r    <= obst_nxt;
      o_pos0_r    <= doac_pkg::POS_W'($signed(pos_nxt[0]));
      o_pos1_r    <= doac_pkg::POS_W'($signed(pos_nxt[1]));
      o_invalid_r <= invalid_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.motor0_dir      = o_dir0_r;
  assign out_chan.motor0_duty     = o_duty0_r;
  assign out_chan.motor1_dir      = o_dir1_r;
  assign out_chan.motor1_duty     = o_duty1_r;
  assign out_chan.avoid_stage     = o_stage_r;
  assign out_chan.obstacle_flag   = o_obst_r;
  assign out_chan.position0       = o_pos0_r;
  assign out_chan.position1       = o_pos1_r;
  assign out_chan.invalid_command = o_invalid_r;

  // Sensing is always off while an avoidance stage runs
  a_no_sense_in_stage: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r != doac_pkg::STG_NONE |-> !sense_r)
    else $error("sensing enabled during avoidance stage");

  // A stop command halts both motors and ends the sequence
  a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && req == doac_pkg::REQ_CMD && in_chan.command_code == doac_pkg::CMD_STOP
    |=> !moving_r && dir_r[0] == doac_pkg::DIR_STOP && dir_r[1] == doac_pkg::DIR_STOP
        && stage_r == doac_pkg::STG_NONE)
    else $error("stop command did not halt");

  // A tick in the done stage resumes: stage none, obstacle cleared, sensing on
  a_done_resumes: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && req == doac_pkg::REQ_TICK && stage_r == doac_pkg::STG_DONE
    |=> stage_r == doac_pkg::STG_NONE && !obst_r && sense_r)
    else $error("done stage did not resume");

endmodule
`default_nettype wire

// ===== tb/tb_drive_obstacle_avoid_controller_core.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_drive_obstacle_avoid_controller_core;
  import doac_pkg::*;

  // One result beat as the block should present it
  typedef struct packed {
    logic [1:0]       dir0;
    logic [PWM_W-1:0] duty0;
    logic [1:0]       dir1;
    logic [PWM_W-1:0] duty1;
    logic [1:0]       stage;
    logic             obstacle;
    logic [POS_W-1:0] pos0;
    logic [POS_W-1:0] pos1;
    logic             invalid;
  } drive_status_t;

  // One event beat on the input channel
  typedef struct {
    req_t              kind;
    logic [CODE_W-1:0] code;
    logic [ECHO_W-1:0] echo;
    logic              enc_motor;
    logic              enc_up;
    logic              turn_right;
  } drive_event_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  doac_in_if  in_chan ();
  doac_out_if out_chan ();

  drive_obstacle_avoid_controller_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Settings as the block should hold them
  logic [THR_W-1:0]   set_thr_cm;
  logic [TIME_W-1:0]  set_reverse_ms;
  logic [TIME_W-1:0]  set_turn_ms;
  logic [PWM_W-1:0]   set_drive_pwm;
  logic [PWM_W-1:0]   set_resume_pwm1;
  logic [PWM_W-1:0]   set_turn_pwm0;
  logic [PWM_W-1:0]   set_turn_pwm1;
  logic [LIMIT_W-1:0] set_travel_limit;

  // Controller state as the block should hold it
  logic [1:0]             ctl_stage;
  mode_t                  ctl_mode;
  logic                   ctl_moving;
  logic                   ctl_obstacle;
  logic                   ctl_sensing;
  logic [TIMER_WIDTH-1:0] ctl_elapsed;
  logic [COUNT_WIDTH-1:0] ctl_pos [2];
  logic [COUNT_WIDTH-1:0] ctl_mark [2];
  dir_t                   ctl_dir [2];
  logic [PWM_W-1:0]       ctl_duty [2];

  drive_status_t expected_status [$];
  int            mismatches = 0;
  int            beats_sent = 0;

  // Idling controls shared by the sender, the receiver and the tests
  bit gaps_on        = 1'b0;
  bit sink_stalls_on = 1'b0;
  int hold_req       = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Generous bound: a few hundred beats, each with worst-case gaps on both sides
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void restore_defaults();
    set_thr_cm       = 10'd50;
    set_reverse_ms   = 16'd1500;
    set_turn_ms      = 16'd1000;
    set_drive_pwm    = 8'd65;
    set_resume_pwm1  = 8'd64;
    set_turn_pwm0    = 8'd45;
    set_turn_pwm1    = 8'd50;
    set_travel_limit = 15'd5000;
    ctl_stage    = AVOID_NONE;
    ctl_mode     = MODE_IDLE;
    ctl_moving   = 1'b0;
    ctl_obstacle = 1'b0;
    ctl_sensing  = 1'b0;
    ctl_elapsed  = '0;
    for (int k = 0; k < 2; k++) begin
      ctl_pos[k]  = '0;
      ctl_mark[k] = '0;
      ctl_dir[k]  = DIR_STOP;
      ctl_duty[k] = '0;
    end
  endfunction

  function automatic void store_setting(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_THRESHOLD:   set_thr_cm       = val[THR_W-1:0];
      CFG_REVERSE_MS:  set_reverse_ms   = val[TIME_W-1:0];
      CFG_TURN_MS:     set_turn_ms      = val[TIME_W-1:0];
      CFG_DRIVE_PWM:   set_drive_pwm    = val[PWM_W-1:0];
      CFG_RESUME_PWM1: set_resume_pwm1  = val[PWM_W-1:0];
      CFG_TURN_PWM0:   set_turn_pwm0    = val[PWM_W-1:0];
      CFG_TURN_PWM1:   set_turn_pwm1    = val[PWM_W-1:0];
      default:         set_travel_limit = val[LIMIT_W-1:0];
    endcase
  endfunction

  function automatic void drive_motor(int m, dir_t d, logic [PWM_W-1:0] duty);
    ctl_dir[m]  = d;
    ctl_duty[m] = duty;
  endfunction

  function automatic void spin_in_place(logic right);
    if (right) begin
      drive_motor(0, DIR_FWD, set_turn_pwm0);
      drive_motor(1, DIR_REV, set_turn_pwm1);
    end else begin
      drive_motor(0, DIR_REV, set_turn_pwm0);
      drive_motor(1, DIR_FWD, set_turn_pwm1);
    end
  endfunction

  function automatic void halt_motors();
    drive_motor(0, DIR_STOP, '0);
    drive_motor(1, DIR_STOP, '0);
  endfunction

  function automatic void bump_elapsed();
    if (ctl_elapsed != '1) ctl_elapsed = ctl_elapsed + 1'b1;
  endfunction

  function automatic void apply_tick(logic right);
    logic [COUNT_WIDTH-1:0] travel;
    // Travel check first; a negative distance never stops a motor
    for (int k = 0; k < 2; k++) begin
      travel = ctl_pos[k] - ctl_mark[k];
      if (!travel[COUNT_WIDTH-1] && travel >= COUNT_WIDTH'(set_travel_limit)) begin
        drive_motor(k, DIR_STOP, '0);
        ctl_mark[k] = ctl_pos[k];
      end
    end
    if (!ctl_moving) return;
    case (ctl_stage)
      AVOID_NONE: begin
        if (ctl_obstacle) begin
          ctl_stage   = AVOID_REVERSE;
          ctl_elapsed = '0;
          ctl_sensing = 1'b0;
          drive_motor(0, DIR_REV, set_drive_pwm);
          drive_motor(1, DIR_REV, set_drive_pwm);
        end
      end
      AVOID_REVERSE: begin
        bump_elapsed();
        if (ctl_elapsed >= set_reverse_ms) begin
          ctl_stage   = AVOID_TURN;
          ctl_elapsed = '0;
          spin_in_place(right);
        end
      end
      AVOID_TURN: begin
        bump_elapsed();
        if (ctl_elapsed >= set_turn_ms) begin
          halt_motors();
          ctl_stage = AVOID_DONE;
        end
      end
      default: begin
        case (ctl_mode)
          MODE_FWD: begin
            drive_motor(0, DIR_FWD, set_drive_pwm);
            drive_motor(1, DIR_FWD, set_resume_pwm1);
          end
          MODE_BACK: begin
            drive_motor(0, DIR_REV, set_drive_pwm);
            drive_motor(1, DIR_REV, set_resume_pwm1);
          end
          MODE_LEFT:  spin_in_place(1'b0);
          MODE_RIGHT: spin_in_place(1'b1);
          default: ;
        endcase
        ctl_stage    = AVOID_NONE;
        ctl_obstacle = 1'b0;
        ctl_sensing  = 1'b1;
      end
    endcase
  endfunction

  // Returns 1 for an unknown byte
  function automatic bit apply_command(logic [CODE_W-1:0] code);
    ctl_stage = AVOID_NONE;
    case (code)
      CMD_FWD: begin
        ctl_moving = 1'b1; ctl_mode = MODE_FWD; ctl_sensing = 1'b1;
        drive_motor(0, DIR_FWD, set_drive_pwm);
        drive_motor(1, DIR_FWD, set_drive_pwm);
      end
      CMD_BACK: begin
        ctl_moving = 1'b1; ctl_mode = MODE_BACK; ctl_sensing = 1'b0;
        drive_motor(0, DIR_REV, set_drive_pwm);
        drive_motor(1, DIR_REV, set_drive_pwm);
      end
      CMD_LEFT: begin
        ctl_moving = 1'b1; ctl_mode = MODE_LEFT; ctl_sensing = 1'b1;
        spin_in_place(1'b0);
      end
      CMD_RIGHT: begin
        ctl_moving = 1'b1; ctl_mode = MODE_RIGHT; ctl_sensing = 1'b1;
        spin_in_place(1'b1);
      end
      CMD_STOP: begin
        ctl_moving = 1'b0; ctl_mode = MODE_IDLE; ctl_sensing = 1'b0;
        ctl_obstacle = 1'b0;
        halt_motors();
      end
      default: return 1'b1;
    endcase
    return 1'b0;
  endfunction

  function automatic drive_status_t advance_controller(drive_event_t ev);
    drive_status_t s;
    bit            bad;
    int unsigned   echo_scaled;
    int unsigned   thr_scaled;
    bad = 1'b0;
    case (ev.kind)
      REQ_TICK: apply_tick(ev.turn_right);
      REQ_CMD:  bad = apply_command(ev.code);
      REQ_ECHO: begin
        if (ctl_sensing && ctl_stage == AVOID_NONE) begin
          echo_scaled  = ev.echo * 17;
          thr_scaled   = set_thr_cm * 1000;
          ctl_obstacle = (echo_scaled < thr_scaled);
          if (ctl_obstacle) halt_motors();
        end
      end
      default: begin
        if (ev.enc_up) ctl_pos[ev.enc_motor] = ctl_pos[ev.enc_motor] + 1'b1;
        else           ctl_pos[ev.enc_motor] = ctl_pos[ev.enc_motor] - 1'b1;
      end
    endcase
    s.dir0     = ctl_dir[0];
    s.duty0    = ctl_duty[0];
    s.dir1     = ctl_dir[1];
    s.duty1    = ctl_duty[1];
    s.stage    = ctl_stage;
    s.obstacle = ctl_obstacle;
    s.pos0     = POS_W'($signed(ctl_pos[0]));
    s.pos1     = POS_W'($signed(ctl_pos[1]));
    s.invalid  = bad;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every accepted result beat against the oldest prediction
  // ---------------------------------------------------------------------------

  function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    drive_status_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready) begin
      if (expected_status.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected", $time);
      end else begin
        want = expected_status.pop_front();
        check_field("motor0_dir", 16'(want.dir0), 16'(out_chan.motor0_dir));
        check_field("motor0_duty", 16'(want.duty0), 16'(out_chan.motor0_duty));
        check_field("motor1_dir", 16'(want.dir1), 16'(out_chan.motor1_dir));
        check_field("motor1_duty", 16'(want.duty1), 16'(out_chan.motor1_duty));
        check_field("avoid_stage", 16'(want.stage), 16'(out_chan.avoid_stage));
        check_field("obstacle_flag", 16'(want.obstacle), 16'(out_chan.obstacle_flag));
        check_field("position0", want.pos0, out_chan.position0);
        check_field("position1", want.pos1, out_chan.position1);
        check_field("invalid_command", 16'(want.invalid), 16'(out_chan.invalid_command));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left > 0) begin
        out_chan.ready = 1'b0;
        stall_left--;
      end else if (sink_stalls_on && $urandom_range(0, 99) < 25) begin
        out_chan.ready = 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Build a beat of the given kind; unused fields still carry random bits
  function automatic drive_event_t make_event(req_t kind);
    drive_event_t ev;
    ev.kind       = kind;
    ev.code       = CODE_W'($urandom_range(0, 255));
    ev.echo       = ECHO_W'($urandom_range(0, 65535));
    ev.enc_motor  = 1'($urandom_range(0, 1));
    ev.enc_up     = 1'($urandom_range(0, 1));
    ev.turn_right = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  // Send one beat: optional idle gap, then hold valid until the block takes it
  task automatic send_beat(drive_event_t ev);
    int gap;
    gap = (gaps_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.req_type        = ev.kind;
    in_chan.command_code    = ev.code;
    in_chan.echo_us         = ev.echo;
    in_chan.encoder_motor   = ev.enc_motor;
    in_chan.encoder_b_level = ev.enc_up;
    in_chan.turn_choice     = ev.turn_right;
    in_chan.valid           = 1'b1;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    expected_status.push_back(advance_controller(ev));
    beats_sent++;
  endtask

  task automatic send_command(logic [CODE_W-1:0] code);
    drive_event_t ev;
    ev = make_event(REQ_CMD);
    ev.code = code;
    send_beat(ev);
  endtask

  task automatic send_echo(logic [ECHO_W-1:0] echo);
    drive_event_t ev;
    ev = make_event(REQ_ECHO);
    ev.echo = echo;
    send_beat(ev);
  endtask

  task automatic send_tick(logic right);
    drive_event_t ev;
    ev = make_event(REQ_TICK);
    ev.turn_right = right;
    send_beat(ev);
  endtask

  task automatic send_edge(logic motor, logic up);
    drive_event_t ev;
    ev = make_event(REQ_ENC);
    ev.enc_motor = motor;
    ev.enc_up    = up;
    send_beat(ev);
  endtask

  // Drop valid, wait for every outstanding result, then let the block sit quiet
  task automatic drain();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    store_setting(idx, val);
  endtask

  task automatic write_all_regs(logic [CFG_DATA_W-1:0] val);
    for (int i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), val);
  endtask

  // Mostly short sequence times and travel limits so the sequence completes
  task automatic write_random_regs();
    write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 1023)));
    write_reg(CFG_REVERSE_MS, CFG_DATA_W'(($urandom_range(0, 9) < 7) ?
              $urandom_range(0, 4) : $urandom_range(0, 65535)));
    write_reg(CFG_TURN_MS, CFG_DATA_W'(($urandom_range(0, 9) < 7) ?
              $urandom_range(0, 4) : $urandom_range(0, 65535)));
    write_reg(CFG_DRIVE_PWM, CFG_DATA_W'($urandom_range(0, 255)));
    write_reg(CFG_RESUME_PWM1, CFG_DATA_W'($urandom_range(0, 255)));
    write_reg(CFG_TURN_PWM0, CFG_DATA_W'($urandom_range(0, 255)));
    write_reg(CFG_TURN_PWM1, CFG_DATA_W'($urandom_range(0, 255)));
    write_reg(CFG_TRAVEL_LIM, CFG_DATA_W'(($urandom_range(0, 9) < 7) ?
              $urandom_range(0, 12) : $urandom_range(0, 32767)));
  endtask

  // Echo times around the obstacle boundary of the current threshold
  function automatic logic [ECHO_W-1:0] echo_near_threshold();
    int unsigned boundary;
    int          r;
    if (set_thr_cm == 0) return ECHO_W'($urandom_range(0, 65535));
    boundary = (set_thr_cm * 1000 - 1) / 17;
    r = $urandom_range(0, 9);
    if (r == 0) return ECHO_W'(boundary);
    if (r == 1) return ECHO_W'(boundary + 1);
    return ECHO_W'($urandom_range(0, boundary));
  endfunction

  function automatic logic [CODE_W-1:0] pick_command();
    case ($urandom_range(0, 5))
      0: return CMD_FWD;
      1: return CMD_BACK;
      2: return CMD_LEFT;
      3: return CMD_RIGHT;
      4: return CMD_STOP;
      default: return CODE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_beat();
    drive_event_t ev;
    int           r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      ev = make_event(REQ_TICK);
    end else if (r < 55) begin
      ev = make_event(REQ_CMD);
      ev.code = pick_command();
    end else if (r < 75) begin
      ev = make_event(REQ_ECHO);
      if ($urandom_range(0, 1)) ev.echo = echo_near_threshold();
    end else begin
      ev = make_event(REQ_ENC);
    end
    send_beat(ev);
  endtask

  // Drive command, a few edges, a close echo, then a random run of ticks that
  // can walk the avoidance sequence when its times are short
  task automatic send_avoid_scenario();
    int span;
    case ($urandom_range(0, 3))
      0: send_command(CMD_FWD);
      1: send_command(CMD_LEFT);
      2: send_command(CMD_RIGHT);
      default: send_command(CMD_BACK);
    endcase
    repeat ($urandom_range(0, 2))
      send_edge(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    send_echo(echo_near_threshold());
    span = int'(set_reverse_ms) + int'(set_turn_ms) + 4;
    if (span > 14) span = 14;
    repeat ($urandom_range(1, span)) send_tick(1'($urandom_range(0, 1)));
  endtask

  task automatic run_random(int count);
    int stop_at;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 2) == 0) send_avoid_scenario();
      else send_random_beat();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every command byte under reset settings, unknown bytes, ignored echo
  task automatic test_commands();
    send_command(CMD_STOP);
    send_tick(1'b0);
    send_echo('0);            // sensing still off: ignored
    send_command(CMD_FWD);
    send_command(CMD_BACK);
    send_command(CMD_LEFT);
    send_command(CMD_RIGHT);
    send_command(8'h00);
    send_command(8'hFF);
    drain();
  endtask

  // Full obstacle sequence with one-tick reverse and zero-length turn
  task automatic test_avoid_sequence();
    write_reg(CFG_REVERSE_MS, 16'd1);
    write_reg(CFG_TURN_MS, 16'd0);
    send_command(CMD_FWD);
    send_echo(16'hFFFF);      // far away: no obstacle
    send_echo(16'h0000);      // right in front: halt
    send_tick(1'b0);          // enter reverse
    send_echo(16'h0000);      // sequence active: ignored
    send_tick(1'b1);          // reverse ends, turn right
    send_tick(1'b0);          // zero turn time ends at once
    send_tick(1'b0);          // done: resume forward
    drain();
  endtask

  // Zero travel limit: any forward travel stops a motor, backward never does
  task automatic test_travel_limit();
    write_reg(CFG_TRAVEL_LIM, 16'd0);
    send_command(CMD_RIGHT);
    send_edge(1'b0, 1'b0);
    send_edge(1'b1, 1'b1);
    send_tick(1'b0);
    drain();
  endtask

  // All registers at their top, then all at zero
  task automatic test_register_extremes();
    write_all_regs(16'hFFFF);
    gaps_on = 1'b1;
    run_random(40);
    drain();
    write_all_regs(16'h0000);
    sink_stalls_on = 1'b1;
    run_random(40);
    drain();
  endtask

  // Several random settings, idling switched on and off between phases
  task automatic test_random_phases();
    for (int phase = 0; phase < 6; phase++) begin
      write_random_regs();
      gaps_on        = (phase != 2);
      sink_stalls_on = (phase != 3);
      run_random(50);
      drain();
    end
  endtask

  // Long receiver hold-off while beats keep coming back to back
  task automatic test_backpressure();
    gaps_on        = 1'b0;
    sink_stalls_on = 1'b0;
    hold_req       = 60;
    run_random(25);
    drain();
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_chan.valid           = 1'b0;
    in_chan.req_type        = REQ_TICK;
    in_chan.command_code    = '0;
    in_chan.echo_us         = '0;
    in_chan.encoder_motor   = 1'b0;
    in_chan.encoder_b_level = 1'b0;
    in_chan.turn_choice     = 1'b0;
    restore_defaults();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(posedge clk);

    test_commands();
    test_avoid_sequence();
    test_travel_limit();
    test_register_extremes();
    test_random_phases();
    test_backpressure();

    drain();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
